FILE: rtl/core/pccs_pkg.sv
// Shared types and constants for the periodic capture channel scheduler.
package pccs_pkg;
    localparam int unsigned NUM_CH    = 16;
    localparam int unsigned CH_W      = 4;
    localparam int unsigned MAX_DEPTH = 256;
    localparam int unsigned PTR_W     = 8;
    localparam int unsigned CNT_W     = 9;
    localparam int unsigned PER_W     = 16;

    localparam logic [2:0] K_REG     = 3'd0;
    localparam logic [2:0] K_START   = 3'd1;
    localparam logic [2:0] K_TICK    = 3'd2;
    localparam logic [2:0] K_READ    = 3'd3;
    localparam logic [2:0] K_RESTART = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNREG = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_CAPT = 2'd1;
    localparam logic [1:0] CS_STOP = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [CH_W-1:0]  channel;
        logic [PER_W-1:0] period;
        logic [CNT_W-1:0] capacity;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [CH_W-1:0]  channel;
        logic [PTR_W-1:0] slot;
        logic             captured;
        logic             ended;
        logic [1:0]       cstate;
        logic             last;
    } t_res;
endpackage

FILE: rtl/core/pccs_front.sv
// Input word queue: accepts commands and buffers them for the executor.
module pccs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  pccs_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    output pccs_pkg::t_cmd  o_cmd,
    input  logic            i_take
);
    import pccs_pkg::*;
    t_cmd       r_q [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_in, w_out;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    always_comb begin
        n_wp  = r_wp ^ w_in;
        n_rp  = r_rp ^ w_out;
        n_cnt = r_cnt + {1'b0, w_in} - {1'b0, w_out};
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end
endmodule

FILE: rtl/core/pccs_exec.sv
// Executor: channel state, tick walk and result output register.
module pccs_exec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pccs_pkg::t_cmd  i_cmd,
    output logic            o_take,
    output logic            o_empty,
    output pccs_pkg::t_res  o_res,
    input  logic            i_pop,
    output logic            o_done
);
    import pccs_pkg::*;
    typedef enum logic [1:0] {S_IDLE = 2'b01, S_TICK = 2'b10} t_state;

    t_state           r_st, n_st;
    logic [NUM_CH-1:0] r_reg, r_arm;
    logic [PER_W-1:0] r_tcnt [NUM_CH];
    logic [PER_W-1:0] r_per  [NUM_CH];
    logic [CNT_W-1:0] r_cap  [NUM_CH];
    logic [PTR_W-1:0] r_wptr [NUM_CH];
    logic [PTR_W-1:0] r_rptr [NUM_CH];
    logic [CNT_W-1:0] r_fill [NUM_CH];
    logic [CH_W-1:0]  r_idx;
    logic             r_ov;
    t_res             r_res;

    logic             w_slot_free;
    logic             w_go, w_tick_go;
    logic [CH_W-1:0]  w_ch, w_free;
    logic             w_has_free;
    logic [CNT_W-1:0] w_capsat;
    logic [PER_W-1:0] w_p, w_tn;
    logic [CNT_W-1:0] w_fn, w_fdec;
    logic [PTR_W:0]   w_wn, w_rn;
    logic             w_act, w_hit, w_end;

    assign o_empty = !r_ov;
    assign o_res   = r_res;
    assign w_slot_free = !r_ov || i_pop;
    assign w_go    = (r_st == S_IDLE) && i_valid && w_slot_free
                     && (i_cmd.kind != K_TICK);
    // A tick walk starts only once the previous word has left.
    assign w_tick_go = (r_st == S_IDLE) && i_valid && !r_ov
                       && (i_cmd.kind == K_TICK);
    assign o_take  = w_go || w_tick_go;
    assign o_done  = r_st == S_IDLE;
    assign w_ch    = i_cmd.channel;

    always_comb begin
        w_has_free = 1'b0;
        w_free     = '0;
        for (int i = NUM_CH - 1; i >= 0; i--) begin
            if (!r_reg[i]) begin
                w_has_free = 1'b1;
                w_free     = CH_W'(i);
            end
        end
        if (i_cmd.capacity == '0) w_capsat = CNT_W'(1);
        else if (i_cmd.capacity > CNT_W'(MAX_DEPTH)) w_capsat = CNT_W'(MAX_DEPTH);
        else w_capsat = i_cmd.capacity;
        w_p    = (r_per[r_idx] == '0) ? PER_W'(1) : r_per[r_idx];
        w_tn   = r_tcnt[r_idx] + PER_W'(1);
        w_act  = r_reg[r_idx] && r_arm[r_idx];
        w_hit  = w_act && (w_tn >= w_p);
        w_wn   = {1'b0, r_wptr[r_idx]} + (PTR_W+1)'(1);
        w_fn   = r_fill[r_idx] + CNT_W'(1);
        w_end  = w_fn >= r_cap[r_idx];
        w_rn   = {1'b0, r_rptr[w_ch]} + (PTR_W+1)'(1);
        w_fdec = r_fill[w_ch] - CNT_W'(1);
        n_st   = r_st;
        unique case (r_st)
            S_IDLE: if (w_tick_go) n_st = S_TICK;
            S_TICK: if (r_idx == CH_W'(NUM_CH - 1) && (!w_hit || w_slot_free))
                        n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_reg <= '0;
            r_arm <= '0;
            r_ov  <= 1'b0;
            r_idx <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_tcnt[i] <= '0; r_wptr[i] <= '0; r_rptr[i] <= '0; r_fill[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (i_pop && r_ov) r_ov <= 1'b0;
            if (w_tick_go) begin
                r_idx <= '0;
            end
            if (w_go) begin
                r_ov  <= 1'b1;
                r_res <= '{status: ST_OK, channel: w_ch, slot: '0, captured: 1'b0,
                           ended: 1'b0, cstate: CS_IDLE, last: 1'b1};
                unique case (i_cmd.kind)
                    K_REG: begin
                        if (!w_has_free) begin
                            r_res.status  <= ST_NOFREE;
                            r_res.channel <= '0;
                        end else begin
                            r_reg[w_free]  <= 1'b1;
                            r_arm[w_free]  <= 1'b0;
                            r_per[w_free]  <= i_cmd.period;
                            r_cap[w_free]  <= w_capsat;
                            r_tcnt[w_free] <= '0;
                            r_wptr[w_free] <= '0;
                            r_rptr[w_free] <= '0;
                            r_fill[w_free] <= '0;
                            r_res.channel  <= w_free;
                        end
                    end
                    K_START, K_READ, K_RESTART: begin
                        if (!r_reg[w_ch]) begin
                            r_res.status <= ST_UNREG;
                        end else if (i_cmd.kind == K_START) begin
                            if (r_fill[w_ch] < r_cap[w_ch]) begin
                                r_arm[w_ch]  <= 1'b1;
                                r_res.cstate <= CS_CAPT;
                            end else begin
                                r_res.cstate <= r_arm[w_ch] ? CS_CAPT : CS_STOP;
                            end
                        end else if (i_cmd.kind == K_READ) begin
                            if (r_fill[w_ch] == '0) begin
                                r_res.status <= ST_EMPTY;
                                r_res.cstate <= r_arm[w_ch] ? CS_CAPT : CS_IDLE;
                            end else begin
                                r_res.slot   <= r_rptr[w_ch];
                                r_rptr[w_ch] <= (w_rn >= (PTR_W+1)'(r_cap[w_ch])) ? '0
                                                : w_rn[PTR_W-1:0];
                                r_fill[w_ch] <= w_fdec;
                                r_res.cstate <= r_arm[w_ch] ? CS_CAPT
                                                : ((w_fdec != '0) ? CS_STOP : CS_IDLE);
                            end
                        end else begin
                            r_arm[w_ch]  <= 1'b0;
                            r_per[w_ch]  <= i_cmd.period;
                            r_tcnt[w_ch] <= '0;
                            r_wptr[w_ch] <= '0;
                            r_rptr[w_ch] <= '0;
                            r_fill[w_ch] <= '0;
                        end
                    end
                    default: r_res.channel <= '0;
                endcase
            end
            if (r_st == S_TICK && (!w_hit || w_slot_free)) begin
                if (r_idx != CH_W'(NUM_CH - 1)) r_idx <= r_idx + CH_W'(1);
                if (w_act) r_tcnt[r_idx] <= w_hit ? '0 : w_tn;
                if (w_hit) begin
                    r_ov  <= 1'b1;
                    r_wptr[r_idx] <= (w_wn >= (PTR_W+1)'(r_cap[r_idx])) ? '0
                                     : w_wn[PTR_W-1:0];
                    r_fill[r_idx] <= w_fn;
                    if (w_end) r_arm[r_idx] <= 1'b0;
                    r_res <= '{status: ST_OK, channel: r_idx, slot: r_wptr[r_idx],
                               captured: 1'b1, ended: w_end,
                               cstate: w_end ? CS_STOP : CS_CAPT, last: 1'b0};
                end
            end
        end
    end

    // Last flag of a tick goes on the final capture; found once the walk ends.
    // Captures are held one step so the final one can be marked.
endmodule

FILE: rtl/core/pccs_tail.sv
// One-word hold stage that marks the final capture of a tick walk.
module pccs_tail (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  pccs_pkg::t_res  i_res,
    output logic            o_pop,
    input  logic            i_done,
    output logic            o_empty,
    output pccs_pkg::t_res  o_res,
    input  logic            i_pop
);
    import pccs_pkg::*;
    logic r_v, r_ok;
    t_res r_h;
    logic w_pend, w_mv;

    // A held capture waits for the next word or the end of the walk to learn its last flag.
    assign w_pend  = r_v && !r_ok;
    assign o_empty = !(r_v && r_ok);
    assign o_res   = r_h;
    assign w_mv    = !i_empty && (!r_v || (r_ok && i_pop));
    assign o_pop   = w_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_ok <= 1'b0;
        end else if (w_mv) begin
            r_v  <= 1'b1;
            r_ok <= !i_res.captured;
            r_h  <= i_res;
        end else if (w_pend) begin
            if (!i_empty) begin
                r_ok <= 1'b1;
                if (!i_res.captured) r_h.last <= 1'b1;
            end else if (i_done) begin
                r_ok     <= 1'b1;
                r_h.last <= 1'b1;
            end
        end else if (!o_empty && i_pop) begin
            r_v  <= 1'b0;
            r_ok <= 1'b0;
        end
    end
endmodule

FILE: rtl/core/periodic_capture_channel_scheduler.sv
// Top level of the periodic capture channel scheduler.
// Usage:
//   Commands enter through a queue port (i_push / o_full) with fields
//   i_kind, i_channel, i_period, i_capacity. Results leave through a queue
//   port (o_empty / i_pop). Each command word gives one result word, except
//   a tick, which gives one word per capturing channel (possibly none), the
//   final one with o_last set.
// Flow: register, start, read and restart pass from the command queue
//   through the executor result register to the tail hold register.
//   A tick starts once the executor output is empty, then walks all 16
//   channels, one per cycle unless a capture waits for the result register;
//   the per-channel walk sets the throughput.
// A two-word command queue lets new commands be accepted while the
//   executor is busy or results wait.
// Reset (synchronous, i_rst_n low) unregisters and disarms all channels and
//   drops queued commands and results.
// When the receiver stalls, the tick walk pauses at the next capture and
//   the command queue fills, then o_full rises.
module periodic_capture_channel_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_period,
    input  logic [8:0]  i_capacity,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_status,
    output logic [3:0]  o_result_channel,
    output logic [7:0]  o_slot,
    output logic        o_captured,
    output logic        o_capture_ended,
    output logic [1:0]  o_channel_state,
    output logic        o_last
);
    import pccs_pkg::*;
    t_cmd w_in, w_cmd;
    t_res w_xres, w_res;
    logic w_valid, w_take, w_xempty, w_xpop, w_done;

    assign w_in = '{kind: i_kind, channel: i_channel, period: i_period,
                    capacity: i_capacity};

    pccs_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_cmd(w_in),
        .o_valid(w_valid), .o_cmd(w_cmd), .i_take(w_take)
    );

    pccs_exec u_exec (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_cmd(w_cmd), .o_take(w_take),
        .o_empty(w_xempty), .o_res(w_xres), .i_pop(w_xpop), .o_done(w_done)
    );

    pccs_tail u_tail (
        .i_clk, .i_rst_n, .i_empty(w_xempty), .i_res(w_xres), .o_pop(w_xpop),
        .i_done(w_done), .o_empty, .o_res(w_res), .i_pop
    );

    assign o_status         = w_res.status;
    assign o_result_channel = w_res.channel;
    assign o_slot           = w_res.slot;
    assign o_captured       = w_res.captured;
    assign o_capture_ended  = w_res.ended;
    assign o_channel_state  = w_res.cstate;
    assign o_last           = w_res.last;
endmodule

FILE: dv/tb_periodic_capture_channel_scheduler.sv
// Testbench for the periodic capture channel scheduler: directed table, random traffic, scoreboard.
module tb_periodic_capture_channel_scheduler;
    import pccs_pkg::*;

    localparam logic [2:0] K_UNDEF_LO = 3'd5;
    localparam logic [2:0] K_UNDEF_HI = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM   = 86;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  ch;
        logic [15:0] per;
        logic [8:0]  cap;
        bit          typed;
        t_res        r;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [2:0]  i_kind = '0;
    logic [3:0]  i_channel = '0;
    logic [15:0] i_period = '0;
    logic [8:0]  i_capacity = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_result_channel;
    logic [7:0]  o_slot;
    logic        o_captured;
    logic        o_capture_ended;
    logic [1:0]  o_channel_state;
    logic        o_last;

    periodic_capture_channel_scheduler DUT (.*);

    always #10 i_clk = ~i_clk;

    // predicted channel state
    logic [15:0] reg_mask = '0, arm_mask = '0;
    logic [15:0] tick_cnt [16] = '{default: '0};
    logic [15:0] ch_per   [16] = '{default: '0};
    logic [8:0]  q_cap    [16] = '{default: '0};
    logic [8:0]  q_fill   [16] = '{default: '0};
    logic [7:0]  wr_ptr   [16] = '{default: '0};
    logic [7:0]  rd_ptr   [16] = '{default: '0};

    t_res expected_words[$];
    t_row pending_rows[$];
    t_row dir_tbl[$];
    int   n_err = 0, n_in = 0, n_out = 0, n_capt = 0, n_ended = 0, idle_cnt = 0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;

    function automatic logic [1:0] chan_state(int c);
        if (arm_mask[c]) return CS_CAPT;
        return (q_fill[c] != 0) ? CS_STOP : CS_IDLE;
    endfunction

    function automatic t_res mk_res(logic [1:0] st, logic [3:0] ch, logic [7:0] sl,
                                    logic cp, logic en, logic [1:0] cs);
        t_res r;
        r.status = st; r.channel = ch; r.slot = sl; r.captured = cp;
        r.ended = en; r.cstate = cs; r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_words(logic [2:0] kind, logic [3:0] ch, logic [15:0] per,
                                 logic [8:0] capin);
        int   c, p, cap, first;
        logic known;
        t_res r;
        known = reg_mask[ch];
        first = expected_words.size();
        case (kind)
            K_REG: begin
                c = 0;
                while (c < 16 && reg_mask[c]) c++;
                if (c >= 16) begin
                    expected_words.push_back(mk_res(ST_NOFREE, 0, 0, 0, 0, CS_IDLE));
                end else begin
                    cap = (capin == 0) ? 1 : (capin > MAX_DEPTH ? MAX_DEPTH : capin);
                    reg_mask[c] = 1'b1; arm_mask[c] = 1'b0;
                    ch_per[c] = per; q_cap[c] = 9'(cap); tick_cnt[c] = 0;
                    wr_ptr[c] = 0; rd_ptr[c] = 0; q_fill[c] = 0;
                    expected_words.push_back(mk_res(ST_OK, 4'(c), 0, 0, 0, chan_state(c)));
                end
            end
            K_START: begin
                if (!known) begin
                    expected_words.push_back(mk_res(ST_UNREG, ch, 0, 0, 0, CS_IDLE));
                end else begin
                    if (q_fill[ch] < q_cap[ch]) arm_mask[ch] = 1'b1;
                    expected_words.push_back(mk_res(ST_OK, ch, 0, 0, 0, chan_state(ch)));
                end
            end
            K_TICK: begin
                for (c = 0; c < 16; c++) begin
                    if (!(reg_mask[c] && arm_mask[c])) continue;
                    p = (ch_per[c] == 0) ? 1 : ch_per[c];
                    tick_cnt[c] = tick_cnt[c] + 16'd1;
                    if (tick_cnt[c] < p) continue;
                    tick_cnt[c] = 0;
                    r = mk_res(ST_OK, 4'(c), wr_ptr[c], 1'b1, 1'b0, CS_IDLE);
                    wr_ptr[c] = (int'(wr_ptr[c]) + 1 >= q_cap[c]) ? 8'd0 : wr_ptr[c] + 8'd1;
                    q_fill[c] = q_fill[c] + 9'd1;
                    if (q_fill[c] >= q_cap[c]) begin
                        arm_mask[c] = 1'b0;
                        r.ended = 1'b1;
                    end
                    r.cstate = chan_state(c);
                    r.last = 1'b0;
                    expected_words.push_back(r);
                end
                if (expected_words.size() > first)
                    expected_words[expected_words.size()-1].last = 1'b1;
            end
            K_READ: begin
                if (!known) begin
                    expected_words.push_back(mk_res(ST_UNREG, ch, 0, 0, 0, CS_IDLE));
                end else if (q_fill[ch] == 0) begin
                    expected_words.push_back(mk_res(ST_EMPTY, ch, 0, 0, 0, chan_state(ch)));
                end else begin
                    r = mk_res(ST_OK, ch, rd_ptr[ch], 0, 0, CS_IDLE);
                    rd_ptr[ch] = (int'(rd_ptr[ch]) + 1 >= q_cap[ch]) ? 8'd0 : rd_ptr[ch] + 8'd1;
                    q_fill[ch] = q_fill[ch] - 9'd1;
                    r.cstate = chan_state(ch);
                    expected_words.push_back(r);
                end
            end
            K_RESTART: begin
                if (!known) begin
                    expected_words.push_back(mk_res(ST_UNREG, ch, 0, 0, 0, CS_IDLE));
                end else begin
                    arm_mask[ch] = 1'b0; ch_per[ch] = per; tick_cnt[ch] = 0;
                    wr_ptr[ch] = 0; rd_ptr[ch] = 0; q_fill[ch] = 0;
                    expected_words.push_back(mk_res(ST_OK, ch, 0, 0, 0, chan_state(ch)));
                end
            end
            default: expected_words.push_back(mk_res(ST_OK, 0, 0, 0, 0, CS_IDLE));
        endcase
    endtask

    task automatic check_word(t_res a);
        t_res e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: channel %0d status %0d", a.channel, a.status);
            n_err++;
            return;
        end
        e = expected_words.pop_front();
        if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status); n_err++;
        end
        if (a.channel !== e.channel) begin
            $error("result_channel: expected %0d, got %0d", e.channel, a.channel); n_err++;
        end
        if (a.slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, a.slot); n_err++;
        end
        if (a.captured !== e.captured) begin
            $error("captured: expected %0d, got %0d", e.captured, a.captured); n_err++;
        end
        if (a.ended !== e.ended) begin
            $error("capture_ended: expected %0d, got %0d", e.ended, a.ended); n_err++;
        end
        if (a.cstate !== e.cstate) begin
            $error("channel_state: expected %0d, got %0d", e.cstate, a.cstate); n_err++;
        end
        if (a.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, a.last); n_err++;
        end
    endtask

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        t_row row;
        t_res act;
        int   first;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_push && !o_full) begin
                row = pending_rows.pop_front();
                first = expected_words.size();
                predict_words(i_kind, i_channel, i_period, i_capacity);
                if (row.typed) begin
                    while (expected_words.size() > first) void'(expected_words.pop_back());
                    expected_words.push_back(row.r);
                end
                n_in++;
                moved = 1'b1;
            end
            if (i_pop && !o_empty) begin
                act = '{o_status, o_result_channel, o_slot, o_captured, o_capture_ended,
                        o_channel_state, o_last};
                if (o_captured === 1'b1) n_capt++;
                if (o_capture_ended === 1'b1) n_ended++;
                check_word(act);
                n_out++;
                moved = 1'b1;
            end
            if (moved) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: changing stall pattern, one long hold
    always @(posedge i_clk) begin
        int mode;
        mode = (n_out / 16) % 3;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (!hold_done && n_out >= 25) begin
            i_pop <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= 300) hold_done <= 1'b1;
        end else if (mode == 0) begin
            i_pop <= 1'b1;
        end else if (mode == 1) begin
            i_pop <= ($urandom_range(0, 1) == 1);
        end else begin
            i_pop <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_word(t_row row);
        pending_rows.push_back(row);
        i_push <= 1'b1;
        i_kind <= row.kind; i_channel <= row.ch;
        i_period <= row.per; i_capacity <= row.cap;
        @(negedge i_clk);
        while (o_full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic add_row(logic [2:0] k, logic [3:0] ch, logic [15:0] per, logic [8:0] cap,
                           bit typed, t_res r);
        t_row row;
        row.kind = k; row.ch = ch; row.per = per; row.cap = cap;
        row.typed = typed; row.r = r;
        dir_tbl.push_back(row);
    endtask

    initial begin
        t_row row;
        t_res nr;
        int   nreg, burst, k;
        nr = '0;

        add_row(K_READ,     0, 0, 1, 1, mk_res(ST_UNREG, 0, 0, 0, 0, CS_IDLE));
        add_row(K_START,   15, 0, 1, 1, mk_res(ST_UNREG, 15, 0, 0, 0, CS_IDLE));
        add_row(K_RESTART,  7, 5, 1, 1, mk_res(ST_UNREG, 7, 0, 0, 0, CS_IDLE));
        add_row(K_UNDEF_LO, 9, 16'hFFFF, 9'h1FF, 1, mk_res(ST_OK, 0, 0, 0, 0, CS_IDLE));
        add_row(K_UNDEF_HI, 3, 1, 1, 1, mk_res(ST_OK, 0, 0, 0, 0, CS_IDLE));
        add_row(K_TICK,     0, 0, 0, 0, nr);
        add_row(K_REG,      0, 0, 0, 1, mk_res(ST_OK, 0, 0, 0, 0, CS_IDLE));
        add_row(K_REG,      0, 16'hFFFF, 9'h1FF, 1, mk_res(ST_OK, 1, 0, 0, 0, CS_IDLE));
        add_row(K_REG,      0, 2, 256, 1, mk_res(ST_OK, 2, 0, 0, 0, CS_IDLE));
        add_row(K_REG,      0, 1, 3, 0, nr);
        add_row(K_START,    0, 0, 0, 0, nr);
        add_row(K_READ,     0, 0, 0, 1, mk_res(ST_EMPTY, 0, 0, 0, 0, CS_CAPT));
        add_row(K_TICK,     0, 0, 0, 0, nr);
        add_row(K_START,    0, 0, 0, 0, nr);
        add_row(K_READ,     0, 0, 0, 0, nr);
        add_row(K_START,    2, 0, 0, 0, nr);
        add_row(K_START,    3, 0, 0, 0, nr);
        add_row(K_START,    1, 0, 0, 0, nr);
        add_row(K_TICK,     0, 0, 0, 0, nr);
        add_row(K_TICK,     0, 0, 0, 0, nr);
        add_row(K_TICK,     0, 0, 0, 0, nr);
        add_row(K_RESTART,  2, 0, 0, 0, nr);
        add_row(K_READ,     3, 0, 0, 0, nr);
        add_row(K_READ,     1, 0, 0, 0, nr);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) send_word(dir_tbl[i]);

        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && i < N_RANDOM; b++, i++) begin
                nreg = $countones(reg_mask);
                k = $urandom_range(0, 99);
                row.typed = 0; row.r = nr;
                row.kind = (k < 14) ? K_REG : (k < 30) ? K_START : (k < 62) ? K_TICK :
                           (k < 84) ? K_READ : (k < 96) ? K_RESTART :
                           3'($urandom_range(K_UNDEF_LO, K_UNDEF_HI));
                row.ch = (nreg > 0 && $urandom_range(0, 7) != 0) ?
                         4'($urandom_range(0, nreg - 1)) : 4'($urandom_range(0, 15));
                row.per = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 3));
                row.cap = ($urandom_range(0, 9) == 0) ? 9'($urandom) :
                          9'($urandom_range(0, 4));
                send_word(row);
                if (i == N_RANDOM / 2) begin
                    i_push <= 1'b0;
                    while (expected_words.size() != 0) @(posedge i_clk);
                end
            end
            i_push <= 1'b0;
            repeat ($urandom_range(0, 8)) @(posedge i_clk);
        end
        i_push <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d command words in, %0d result words out, %0d captures, %0d queue fills",
                 n_in, n_out, n_capt, n_ended);
        $display("channels registered at end: %0d of 16", $countones(reg_mask));
        if (n_err == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
